@@ design/ootr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ootr_pkg
// Shared types and constants of the onset/offset note tracker.
// ----------------------------------------------------------------------------
package ootr_pkg;

  // number of tracked pitches and the width of a pitch index
  localparam int PITCHES = 88;
  localparam int PIDX_W  = (PITCHES > 1) ? $clog2(PITCHES) : 1;

  // depth of the queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);

  // stream widths
  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 80;
  localparam int CFG_W     = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_THRESH    = 2'd0,
    CFG_VEL_SCALE       = 2'd1,
    CFG_BASE_NOTE       = 2'd2,
    CFG_MAX_NOTE_FRAMES = 2'd3
  } cfg_idx_e;

  // reset values of the configuration registers
  localparam logic [15:0] RST_FRAME_THRESH    = 16'd19661;
  localparam logic [7:0]  RST_VEL_SCALE       = 8'd128;
  localparam logic [6:0]  RST_BASE_NOTE       = 7'd21;
  localparam logic [15:0] RST_MAX_NOTE_FRAMES = 16'd600;

  typedef struct packed {
    logic [15:0] frame_thresh;
    logic [7:0]  vel_scale;
    logic [6:0]  base_note;
    logic [15:0] max_note_frames;
  } cfg_t;

  // one input item after unpacking
  typedef struct packed {
    logic [6:0]         pitch;
    logic [15:0]        frame_index;
    logic               last_frame;
    logic [15:0]        frame_prob;
    logic               onset_hit;
    logic signed [15:0] on_shift;
    logic               offset_hit;
    logic signed [15:0] off_shift;
    logic [15:0]        velocity_prob;
  } item_t;

  // per-pitch stored note context
  typedef struct packed {
    logic [15:0] note_start;
    logic [15:0] start_shift;
    logic [15:0] start_velocity;
    logic [15:0] offset_frame;
    logic [15:0] off_shift;
  } entry_t;

  // one emitted note
  typedef struct packed {
    logic [7:0]         velocity;
    logic signed [15:0] end_shift;
    logic signed [15:0] start_shift;
    logic [15:0]        end_frame;
    logic [15:0]        start_frame;
    logic [7:0]         note_number;
  } result_t;

endpackage

@@ design/onset_offset_note_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onset_offset_note_tracker_top
// Per-pitch note tracker built from onset, offset and frame activity.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one item per pitch per frame; tlast marks the
//   final frame of the stream. Each item closes at most one note, which
//   leaves on the master stream as one transaction. Items with a pitch
//   beyond the tracked range are taken and dropped.
//   Throughput is one item per clock unless the receiver stalls: the
//   per-pitch context sits in a single memory, read as an item enters the
//   execute stage and written as it leaves, with a bypass when consecutive
//   items hit the same pitch. An item passes the input register, the queue,
//   the memory read and the result register before its result is valid.
//   When the receiver stalls, the result register holds, the tracker stage
//   stops, and the four-entry queue plus the input register absorb items
//   before s_axis_tready falls.
//   Reset clears all note and offset flags at once; no clearing pass is
//   needed. Configuration registers return to their defaults; the user writes
//   them via cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle (not enforced).
// ----------------------------------------------------------------------------
module onset_offset_note_tracker_top
  import ootr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata, low bit up: pitch[6:0], frame_index[22:7], frame_prob[38:23],
  // onset_hit[39], on_shift[55:40], offset_hit[56], off_shift[72:57],
  // velocity_prob[88:73], zero fill[95:89]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,   // last_frame
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata, low bit up: note_number[7:0], start_frame[23:8], end_frame[39:24],
  // start_shift[55:40], end_shift[71:56], velocity[79:72]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  cfg_t  cfg_q;
  logic  f_valid;
  item_t f_item;
  logic  f_ready;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_thresh    <= RST_FRAME_THRESH;
      cfg_q.vel_scale       <= RST_VEL_SCALE;
      cfg_q.base_note       <= RST_BASE_NOTE;
      cfg_q.max_note_frames <= RST_MAX_NOTE_FRAMES;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_THRESH:    cfg_q.frame_thresh    <= cfg_wdata_i;
        CFG_VEL_SCALE:       cfg_q.vel_scale       <= cfg_wdata_i[7:0];
        CFG_BASE_NOTE:       cfg_q.base_note       <= cfg_wdata_i[6:0];
        CFG_MAX_NOTE_FRAMES: cfg_q.max_note_frames <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ootr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .item_valid_o  (f_valid),
    .item_o        (f_item),
    .item_ready_i  (f_ready)
  );

  ootr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (f_valid),
    .push_item_i  (f_item),
    .push_ready_o (f_ready),
    .pop_valid_o  (q_valid),
    .pop_item_o   (q_item),
    .pop_i        (q_pop)
  );

  ootr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .item_pop_o    (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ design/ootr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ootr_front
// Input stage: takes stream transactions, unpacks the item and drops pitches
// that have no tracker before handing the item to the queue.
// ----------------------------------------------------------------------------
module ootr_front
  import ootr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata, low bit up: pitch[6:0], frame_index[22:7], frame_prob[38:23],
  // onset_hit[39], on_shift[55:40], offset_hit[56], off_shift[72:57],
  // velocity_prob[88:73], zero fill[95:89]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,   // last_frame
  output logic                 item_valid_o,
  output item_t                item_o,
  input  logic                 item_ready_i
);

  logic  vld_q;
  item_t item_q;
  item_t item_d;
  logic  accept;
  logic  in_range;
  logic  load;

  // unpack the transaction
  always_comb begin
    item_d.pitch         = s_axis_tdata[6:0];
    item_d.frame_index   = s_axis_tdata[22:7];
    item_d.last_frame    = s_axis_tlast;
    item_d.frame_prob    = s_axis_tdata[38:23];
    item_d.onset_hit     = s_axis_tdata[39];
    item_d.on_shift      = s_axis_tdata[55:40];
    item_d.offset_hit    = s_axis_tdata[56];
    item_d.off_shift     = s_axis_tdata[72:57];
    item_d.velocity_prob = s_axis_tdata[88:73];
  end

  // pitches without a tracker cause nothing
  assign in_range      = ({1'b0, item_d.pitch} < 8'(PITCHES));
  assign load          = !vld_q || item_ready_i;
  assign s_axis_tready = load;
  assign accept        = s_axis_tvalid && load;

  // holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= accept && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

@@ design/ootr_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ootr_fifo
// Short item queue between the front stage and the tracker back end.
// ----------------------------------------------------------------------------
module ootr_fifo
  import ootr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output item_t pop_item_o,
  input  logic  pop_i
);

  item_t             buf_q [FIFO_DEPTH];
  logic [FPTR_W:0]   wr_ptr_q;
  logic [FPTR_W:0]   rd_ptr_q;
  logic              full;
  logic              empty;
  logic              do_push;
  logic              do_pop;

  assign empty   = (wr_ptr_q == rd_ptr_q);
  assign full    = (wr_ptr_q[FPTR_W] != rd_ptr_q[FPTR_W]) &&
                   (wr_ptr_q[FPTR_W-1:0] == rd_ptr_q[FPTR_W-1:0]);
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && !empty;

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q[FPTR_W-1:0]] <= push_item_i;
    end
  end

  assign push_ready_o = !full;
  assign pop_valid_o  = !empty;
  assign pop_item_o   = buf_q[rd_ptr_q[FPTR_W-1:0]];

endmodule

@@ design/ootr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ootr_back
// Tracker back end: per-pitch read-modify-write of the note context, note
// close decisions and the result register.
// ----------------------------------------------------------------------------
module ootr_back
  import ootr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 item_valid_i,
  input  item_t                item_i,
  output logic                 item_pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata, low bit up: note_number[7:0], start_frame[23:8], end_frame[39:24],
  // start_shift[55:40], end_shift[71:56], velocity[79:72]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  // context memory and valid flags
  entry_t             mem_q [PITCHES];
  entry_t             rd_q;
  logic [PITCHES-1:0] active_q;
  logic [PITCHES-1:0] seen_q;

  // execute stage
  logic               s1_vld_q;
  item_t              s1_q;
  logic               fwd_q;
  entry_t             fwd_data_q;

  // result register
  logic               out_vld_q;
  result_t            out_q;

  logic               adv1;
  logic               pop;
  logic [PIDX_W-1:0]  pidx;
  logic [PIDX_W-1:0]  head_idx;

  entry_t             e;
  entry_t             ne;
  logic               act;
  logic               seen;
  logic               act_n;
  logic               seen_n;
  logic               emit;
  logic [15:0]        endf;
  logic [15:0]        endsh;
  logic [15:0]        since;
  logic [15:0]        dist_a;
  logic [15:0]        dist_b;
  logic [23:0]        vel_prod;
  result_t            res;

  assign adv1       = !out_vld_q || m_axis_tready;
  assign pop        = item_valid_i && (!s1_vld_q || adv1);
  assign item_pop_o = pop;
  assign pidx       = s1_q.pitch[PIDX_W-1:0];
  assign head_idx   = item_i.pitch[PIDX_W-1:0];

  // note decision for the item in the execute stage
  always_comb begin
    e      = fwd_q ? fwd_data_q : rd_q;
    act    = active_q[pidx];
    seen   = seen_q[pidx];
    ne     = e;
    act_n  = act;
    seen_n = seen;
    emit   = 1'b0;
    endf   = s1_q.frame_index;
    endsh  = s1_q.off_shift;
    since  = s1_q.frame_index - e.note_start;
    dist_a = '0;
    dist_b = '0;
    if (s1_q.onset_hit) begin
      // a new onset cuts any open note at the previous frame
      if (act) begin
        emit  = 1'b1;
        endf  = (s1_q.frame_index == 16'd0) ? 16'd0 : s1_q.frame_index - 16'd1;
        endsh = 16'd0;
      end
      act_n             = 1'b1;
      seen_n            = 1'b0;
      ne.note_start     = s1_q.frame_index;
      ne.start_shift    = s1_q.on_shift;
      ne.start_velocity = s1_q.velocity_prob;
    end else if (act && (since != 16'd0)) begin
      // keep the first offset hit of the note
      if (s1_q.offset_hit && !seen) begin
        seen_n          = 1'b1;
        ne.offset_frame = s1_q.frame_index;
        ne.off_shift    = s1_q.off_shift;
      end
      dist_a = ne.offset_frame - e.note_start;
      dist_b = s1_q.frame_index - ne.offset_frame;
      if (s1_q.frame_prob <= cfg_i.frame_thresh) begin
        // frame drop: end at the held offset if it is nearer the drop
        emit = 1'b1;
        if (seen_n && (dist_a > dist_b)) begin
          endf  = ne.offset_frame;
          endsh = ne.off_shift;
        end
        act_n  = 1'b0;
        seen_n = 1'b0;
      end else if ((since >= cfg_i.max_note_frames) || s1_q.last_frame) begin
        emit   = 1'b1;
        act_n  = 1'b0;
        seen_n = 1'b0;
      end
    end
    // end of stream clears the tracker
    if (s1_q.last_frame) begin
      act_n  = 1'b0;
      seen_n = 1'b0;
    end
  end

  // result fields; the 16x8 product shifted by 16 never exceeds 255
  assign vel_prod = 24'(e.start_velocity) * 24'(cfg_i.vel_scale);

  always_comb begin
    res.note_number = {1'b0, s1_q.pitch} + {1'b0, cfg_i.base_note};
    res.start_frame = e.note_start;
    res.end_frame   = endf;
    res.start_shift = e.start_shift;
    res.end_shift   = endsh;
    res.velocity    = vel_prod[23:16];
  end

  // stage control, valid flags and bypass of the write the next read misses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_q     <= 1'b0;
      active_q  <= '0;
      seen_q    <= '0;
    end else begin
      if (!s1_vld_q || adv1) begin
        s1_vld_q <= item_valid_i;
        fwd_q    <= pop && s1_vld_q && adv1 && (item_i.pitch == s1_q.pitch);
      end
      if (adv1) begin
        out_vld_q <= s1_vld_q && emit;
      end
      if (adv1 && s1_vld_q) begin
        active_q[pidx] <= act_n;
        seen_q[pidx]   <= seen_n;
      end
    end
  end

  // payload registers and context memory
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_q <= item_i;
      rd_q <= mem_q[head_idx];
    end
    if (adv1 && s1_vld_q) begin
      mem_q[pidx] <= ne;
      fwd_data_q  <= ne;
    end
    if (adv1) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.velocity, out_q.end_shift, out_q.start_shift,
                          out_q.end_frame, out_q.start_frame, out_q.note_number};

endmodule
